FILE: src/ilbs_pkg.sv
// Shared types and constants of the indexed lower-bound search core.
// No dependencies; imported by the front, back and top-level modules.
package ilbs_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned POS_W       = 11;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [POS_W-1:0] COUNT_MAX = POS_W'(TABLE_DEPTH);
  localparam logic             REG_ENTRY_COUNT = 1'b0;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                kind;
    logic [ADDR_W-1:0]        entry_addr;
    logic signed [KEY_W-1:0]  entry_key;
    logic [ADDR_W-1:0]        entry_order;
    logic signed [KEY_W-1:0]  query_key;
    logic [ADDR_W-1:0]        start_pos;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_CMP
  } back_state_e;

endpackage

FILE: src/indexed_lower_bound_search_core.sv
// Indexed lower-bound search core: stream input with load and query items,
// one search result per query on the output stream, entry_count on an APB port.
// The slave stream carries items; tuser selects a load (0) or a query (1).
// A load writes one slot of the key store and of the order store and gives
// no transfer on the master stream. A query bisects the sorted positions
// start_pos .. entry_count-1 and returns the first position whose key is at
// least query_key, or entry_count when there is none.
// Items enter a two-entry queue, so the input keeps taking transfers while
// the search runs or a result waits, as long as the queue has room.
// A query makes at most 11 probes at full depth; each probe is one
// registered read of the order memory followed by one of the key memory;
// when start_pos is at or past entry_count the result needs no probe.
// The result register holds while m_axis_tready is low; the next query then
// waits in the queue, loads continue. Reset empties queue and result register
// and sets entry_count to 1024; the stores are undefined until written.
// Depends on ilbs_pkg, ilbs_front and ilbs_back.
module indexed_lower_bound_search_core import ilbs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // entry_addr[9:0], entry_key[41:10], entry_order[51:42],
  // query_key[83:52], start_pos[93:84], zero fill[95:94]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // found_pos[10:0], zero fill[15:11]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  logic             count_we;
  logic [POS_W-1:0] count_q, count_d;
  logic             cmd_valid, cmd_ready;
  cmd_t             cmd;

  assign pready   = 1'b1;
  assign count_we = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);
  assign count_d  = (pwdata[POS_W-1:0] > COUNT_MAX) ? COUNT_MAX : pwdata[POS_W-1:0];
  assign prdata   = (paddr[2] == REG_ENTRY_COUNT) ?
                    {{(APB_DATA_W - POS_W){1'b0}}, count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_MAX;
    end else if (count_we) begin
      count_q <= count_d;
    end
  end

  ilbs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  ilbs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .count_i       (count_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: src/ilbs_front.sv
// Input front end: takes stream transfers, classifies them as loads or queries
// and holds them in a two-entry command queue. Depends on ilbs_pkg.
module ilbs_front import ilbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // entry_addr, entry_key, entry_order, query_key, start_pos, zero fill
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  // action
  input  logic                  s_axis_tuser,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output cmd_t                  cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  cmd_t       cmd_in;
  logic       push, pop;

  always_comb begin
    cmd_in.kind        = s_axis_tuser ? CMD_QUERY : CMD_LOAD;
    cmd_in.entry_addr  = s_axis_tdata[9:0];
    cmd_in.entry_key   = s_axis_tdata[41:10];
    cmd_in.entry_order = s_axis_tdata[51:42];
    cmd_in.query_key   = s_axis_tdata[83:52];
    cmd_in.start_pos   = s_axis_tdata[93:84];
  end

  assign s_axis_tready = (fill_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (fill_q != 2'd0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: src/ilbs_back.sv
// Search back end: key and order memories, the bisection sequencer and the
// result register. Depends on ilbs_pkg; fed by ilbs_front.
module ilbs_back import ilbs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [POS_W-1:0]       count_i,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  cmd_t                   cmd_i,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // found_pos, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [ADDR_W-1:0]       order_mem [TABLE_DEPTH];

  back_state_e             state_q, state_d;
  logic [POS_W-1:0]        lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic signed [KEY_W-1:0] qkey_q, qkey_d;
  logic signed [KEY_W-1:0] key_q;
  logic [ADDR_W-1:0]       order_q;
  logic                    out_valid_q, out_valid_d;
  logic [POS_W-1:0]        out_pos_q, out_pos_d;

  logic                    mem_we, ord_rd, key_rd, res_we;
  logic [ADDR_W-1:0]       ord_addr;
  logic [POS_W-1:0]        res_pos;
  logic [POS_W:0]          sum_start, sum_next;
  logic                    below;
  logic [POS_W-1:0]        nlo, nhi;
  logic                    cmd_take;

  assign below     = key_q < qkey_q;
  assign nlo       = below ? POS_W'(mid_q + 1'b1) : lo_q;
  assign nhi       = below ? hi_q : mid_q;
  assign sum_start = {2'b00, cmd_i.start_pos} + {1'b0, count_i};
  assign sum_next  = {1'b0, nlo} + {1'b0, nhi};
  assign cmd_take  = cmd_valid_i && cmd_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_take && (cmd_i.kind == CMD_QUERY) &&
            ({1'b0, cmd_i.start_pos} < count_i)) begin
          state_d = ST_KEY;
        end
      end
      ST_KEY: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = (nlo < nhi) ? ST_KEY : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    ord_rd      = 1'b0;
    ord_addr    = '0;
    key_rd      = 1'b0;
    res_we      = 1'b0;
    res_pos     = nlo;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    qkey_d      = qkey_q;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = (cmd_i.kind == CMD_LOAD) || !out_valid_q;
        if (cmd_take) begin
          if (cmd_i.kind == CMD_LOAD) begin
            mem_we = 1'b1;
          end else if ({1'b0, cmd_i.start_pos} < count_i) begin
            lo_d     = {1'b0, cmd_i.start_pos};
            hi_d     = count_i;
            mid_d    = sum_start[POS_W:1];
            qkey_d   = cmd_i.query_key;
            ord_rd   = 1'b1;
            ord_addr = sum_start[ADDR_W:1];
          end else begin
            res_we  = 1'b1;
            res_pos = count_i;
          end
        end
      end
      ST_KEY: begin
        key_rd = 1'b1;
      end
      ST_CMP: begin
        lo_d  = nlo;
        hi_d  = nhi;
        mid_d = sum_next[POS_W:1];
        if (nlo < nhi) begin
          ord_rd   = 1'b1;
          ord_addr = sum_next[ADDR_W:1];
        end else begin
          res_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_pos_d   = out_pos_q;
    if (res_we) begin
      out_valid_d = 1'b1;
      out_pos_d   = res_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    qkey_q    <= qkey_d;
    out_pos_q <= out_pos_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      order_mem[cmd_i.entry_addr] <= cmd_i.entry_order;
    end
    if (ord_rd) begin
      order_q <= order_mem[ord_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[cmd_i.entry_addr] <= cmd_i.entry_key;
    end
    if (key_rd) begin
      key_q <= key_mem[order_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - POS_W){1'b0}}, out_pos_q};

`ifndef ASSERT_OFF
  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we |-> !out_valid_q)
    else $error("Result written while the output register is occupied.");

  a_cmd_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |-> (state_q == ST_IDLE))
    else $error("Command taken while a search is in progress.");

  a_range_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KEY) |-> ((lo_q < hi_q) && (hi_q <= count_i) && (mid_q < hi_q)))
    else $error("Bisection range is empty or out of bounds during a probe.");

  a_key_follows_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KEY) |-> $past(ord_rd))
    else $error("Key probe without a preceding order read.");
`endif

endmodule

FILE: tb/sv/indexed_lower_bound_search_core_tb.sv
`timescale 1ns / 100ps
// Testbench for indexed_lower_bound_search_core: fills the key and order tables,
// runs lower-bound searches and checks each result against a search predictor.
// Depends on ilbs_pkg and the core RTL; needs no files or arguments.
module indexed_lower_bound_search_core_tb;
  import ilbs_pkg::*;

  localparam int unsigned REG_SPARE    = 1;
  localparam int unsigned IDLE_PAD     = 80;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned WINDOW_MAX   = 48;
  localparam int unsigned COUNT_FIELD_MAX = (1 << POS_W) - 1;
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  class search_scoreboard;
    logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]       order_mem [TABLE_DEPTH];
    bit                      written [TABLE_DEPTH];
    int unsigned             count = TABLE_DEPTH;
    logic [POS_W-1:0]        found_q [$];

    function void set_count(input logic [APB_DATA_W-1:0] value);
      int unsigned c;
      c = value[POS_W-1:0];
      count = (c > TABLE_DEPTH) ? TABLE_DEPTH : c;
    endfunction

    function int unsigned lower_bound(input logic signed [KEY_W-1:0] q,
                                      input int unsigned start);
      int unsigned lo, hi, mid;
      lo = start;
      hi = count;
      if (lo >= hi) return hi;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (key_mem[order_mem[mid]] < q) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    // True when every probe of this search lands on entries already loaded.
    function bit probes_written(input logic signed [KEY_W-1:0] q,
                                input int unsigned start);
      int unsigned lo, hi, mid;
      lo = start;
      hi = count;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (!written[mid] || !written[order_mem[mid]]) return 0;
        if (key_mem[order_mem[mid]] < q) lo = mid + 1;
        else hi = mid;
      end
      return 1;
    endfunction

    function void note_item(input cmd_t c);
      if (c.kind == CMD_LOAD) begin
        key_mem[c.entry_addr]   = c.entry_key;
        order_mem[c.entry_addr] = c.entry_order;
        written[c.entry_addr]   = 1'b1;
      end else begin
        found_q.push_back(POS_W'(lower_bound(c.query_key, c.start_pos)));
      end
    endfunction

    function bit check_found(input logic [POS_W-1:0] got, output string why);
      logic [POS_W-1:0] want;
      why = "";
      if (found_q.size() == 0) begin
        why = $sformatf("found_pos %0d arrived with no search pending", got);
        return 0;
      end
      want = found_q.pop_front();
      if (got !== want) begin
        why = $sformatf("found_pos %0d, expected %0d", got, want);
        return 0;
      end
      return 1;
    endfunction

    function int pending();
      return found_q.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  search_scoreboard sb = new();
  int          errors = 0;
  int unsigned items_sent = 0;
  int          burst_left = 8;
  int unsigned idle_cycles = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  logic [31:0] rx_cycle = '0;
  int          top_keys [8] = '{int'(KEY_MIN), -5, 0, 0, 0, 7, 100, int'(KEY_MAX)};

  indexed_lower_bound_search_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string why);
    errors++;
    $display("[%0t] search result mismatch: %s", $time, why);
  endtask

  // The receiver checks each result transfer, then picks its next ready value.
  always @(posedge clk_i) begin
    string why;
    if (m_axis_tvalid && m_axis_tready && !sb.check_found(m_axis_tdata[POS_W-1:0], why))
      report_mismatch(why);
    rx_cycle <= rx_cycle + 1;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_cycle[9:8])
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
        2'd2: m_axis_tready <= (rx_cycle[1:0] == 2'd0);
        default: m_axis_tready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    do @(posedge clk_i); while (idle_cycles < STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic cmd_t load_cmd(input int unsigned addr, input int key,
                                    input int unsigned order);
    cmd_t c;
    c.kind        = CMD_LOAD;
    c.entry_addr  = ADDR_W'(addr);
    c.entry_key   = key;
    c.entry_order = ADDR_W'(order);
    c.query_key   = $urandom;
    c.start_pos   = ADDR_W'($urandom);
    return c;
  endfunction

  function automatic cmd_t query_cmd(input int key, input int unsigned start);
    cmd_t c;
    c.kind        = CMD_QUERY;
    c.entry_addr  = ADDR_W'($urandom);
    c.entry_key   = $urandom;
    c.entry_order = ADDR_W'($urandom);
    c.query_key   = key;
    c.start_pos   = ADDR_W'(start);
    return c;
  endfunction

  function automatic int unsigned pick_count();
    case ($urandom_range(0, 9))
      0: return TABLE_DEPTH;
      1: return $urandom_range(1, TABLE_DEPTH);
      2: return TABLE_DEPTH - 1;
      3: return 0;
      4: return $urandom_range(TABLE_DEPTH + 1, COUNT_FIELD_MAX);
      default: return $urandom_range(1, WINDOW_MAX);
    endcase
  endfunction

  // Builds a search whose probes touch only loaded entries; fails when none fits.
  function automatic bit make_query(input int unsigned base, output cmd_t c);
    int unsigned cnt, start, pos;
    int key;
    cnt = sb.count;
    case ($urandom_range(0, 7))
      0: key = $urandom;
      1: key = KEY_MIN;
      2: key = KEY_MAX;
      default: begin
        key = $urandom;
        if (cnt > base) begin
          pos = $urandom_range(base, cnt - 1);
          if (sb.written[pos] && sb.written[sb.order_mem[pos]])
            key = sb.key_mem[sb.order_mem[pos]] + int'($urandom_range(0, 2)) - 1;
        end
      end
    endcase
    case ($urandom_range(0, 7))
      0: start = (cnt > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : $urandom_range(cnt, TABLE_DEPTH - 1);
      1: start = $urandom_range(0, TABLE_DEPTH - 1);
      2: start = base;
      default: start = (cnt > base) ? $urandom_range(base, cnt - 1) : base;
    endcase
    if (!sb.probes_written(key, start)) start = base;
    if (!sb.probes_written(key, start)) begin
      if (cnt > TABLE_DEPTH - 1) return 0;
      start = $urandom_range(cnt, TABLE_DEPTH - 1);
    end
    c = query_cmd(key, start);
    return 1;
  endfunction

  task automatic send_item(input cmd_t c, input bit allow_gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({c.start_pos, c.query_key, c.entry_order, c.entry_key,
                                  c.entry_addr});
    s_axis_tuser  <= c.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(c);
    items_sent++;
    if (allow_gap) begin
      burst_left--;
      if (burst_left <= 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
      end
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (IDLE_PAD) @(posedge clk_i);
  endtask

  task automatic apb_write(input int unsigned reg_idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(reg_idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_idx == REG_ENTRY_COUNT) sb.set_count(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_entry_count(input int unsigned value);
    wait_idle();
    apb_write(REG_ENTRY_COUNT, value);
  endtask

  // Loads positions base..base+len-1 with ascending keys reached through a
  // shuffled order table that points back into the same window.
  task automatic fill_window(input int unsigned base, input int unsigned len);
    int keys [$];
    int unsigned perm [$];
    int unsigned j, tmp;
    bit narrow;
    narrow = $urandom_range(0, 2) == 0;
    for (int unsigned i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) keys.push_back(keys[i-1]);
      else if (narrow) keys.push_back(int'($urandom_range(0, 40)) - 20);
      else keys.push_back(int'($urandom));
      perm.push_back(base + i);
    end
    keys.sort();
    for (int i = int'(len) - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int unsigned i = 0; i < len; i++)
      send_item(load_cmd(perm[i], keys[i], perm[perm[i] - base]), 1'b1);
  endtask

  task automatic run_mixed(input int unsigned base, input int unsigned n);
    cmd_t c;
    int unsigned r, cnt;
    cnt = sb.count;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        if (make_query(base, c)) send_item(c, 1'b1);
      end else if (r < 86 && cnt > base) begin
        send_item(load_cmd($urandom_range(base, cnt - 1), $urandom,
                           $urandom_range(base, cnt - 1)), 1'b1);
      end else begin
        send_item(load_cmd($urandom_range(0, TABLE_DEPTH - 1), $urandom,
                           $urandom_range(0, TABLE_DEPTH - 1)), 1'b1);
      end
    end
  endtask

  initial begin
    cmd_t c;
    int unsigned cnt, base, len, phase, random_from;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Top window at the reset count: extreme keys, an equal run, orders reversed.
    for (int unsigned a = TABLE_DEPTH - 8; a < TABLE_DEPTH; a++)
      send_item(load_cmd(a, top_keys[TABLE_DEPTH - 1 - a], 2 * TABLE_DEPTH - 9 - a), 1'b1);
    send_item(query_cmd(KEY_MIN, TABLE_DEPTH - 8), 1'b1);
    send_item(query_cmd(0, TABLE_DEPTH - 8), 1'b1);
    send_item(query_cmd(1, TABLE_DEPTH - 8), 1'b1);
    send_item(query_cmd(KEY_MAX, TABLE_DEPTH - 8), 1'b1);
    send_item(query_cmd(-5, TABLE_DEPTH - 4), 1'b1);
    send_item(query_cmd(KEY_MAX, TABLE_DEPTH - 1), 1'b1);
    set_entry_count(TABLE_DEPTH - 2);
    send_item(query_cmd(200, TABLE_DEPTH - 8), 1'b1);
    send_item(query_cmd(0, TABLE_DEPTH - 1), 1'b1);
    set_entry_count(0);
    send_item(query_cmd(KEY_MAX, 0), 1'b1);
    set_entry_count(COUNT_FIELD_MAX);
    send_item(query_cmd(1, TABLE_DEPTH - 8), 1'b1);
    wait_idle();
    apb_write(REG_SPARE, 5);
    send_item(query_cmd(0, TABLE_DEPTH - 1), 1'b1);
    set_entry_count(1);
    send_item(load_cmd(0, 0, 0), 1'b1);
    send_item(query_cmd(0, 0), 1'b1);
    send_item(query_cmd(1, 0), 1'b1);
    send_item(query_cmd(-1, TABLE_DEPTH - 1), 1'b1);

    phase = 0;
    random_from = items_sent;
    while (items_sent - random_from < RANDOM_ITEMS) begin
      if (phase == 0) set_entry_count(TABLE_DEPTH);
      else if (phase == 1) set_entry_count(1);
      else set_entry_count(pick_count());
      cnt = sb.count;
      len = (cnt == 0) ? 0 : $urandom_range(1, (cnt < WINDOW_MAX) ? cnt : WINDOW_MAX);
      base = cnt - len;
      if (len > 0 && (phase < 2 || $urandom_range(0, 3) != 0)) fill_window(base, len);
      if (phase == 0) begin
        // The result side holds off while searches keep coming, so the input backs up.
        hold_req = 1'b1;
        repeat (16) if (make_query(base, c)) send_item(c, 1'b0);
      end
      if (phase == 1) begin
        run_mixed(base, 10);
        wait_drained();
        run_mixed(base, 10);
      end else begin
        run_mixed(base, $urandom_range(10, 40));
      end
      phase++;
    end

    wait_drained();
    repeat (IDLE_PAD) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
